// File: rtl/core/kalman_tempo_phase_tracker_top_defines.svh
// Assertion macros for the tempo and phase tracker.
`ifndef KALMAN_TEMPO_PHASE_TRACKER_TOP_DEFINES_SVH
`define KALMAN_TEMPO_PHASE_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KTPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KTPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KTPT_ASSERT(lbl, prop, msg)
`define KTPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/ktpt_pkg.sv
package ktpt_pkg;

  localparam int MagW    = 64;
  localparam int NumMem  = 22;
  localparam int PcW     = 6;
  localparam logic [PcW-1:0] PcRestart = 6'd43;

  typedef enum logic [2:0] {
    CFG_Q_PHASE, CFG_Q_TEMPO, CFG_R_PHASE, CFG_R_TEMPO, CFG_PHASE_GATE, CFG_TEMPO_GATE
  } cfg_idx_e;

  // Scratch memory entries come first, the fixed sources after them.
  typedef enum logic [4:0] {
    SRC_PH, SRC_PER, SRC_P00, SRC_P01, SRC_P10, SRC_P11,
    SRC_H00, SRC_H01, SRC_H10, SRC_H11, SRC_S00, SRC_S11, SRC_DET,
    SRC_K00, SRC_K01, SRC_K10, SRC_K11, SRC_Y0, SRC_Y1, SRC_T0, SRC_T1, SRC_T2,
    SRC_M0, SRC_M1, SRC_QP, SRC_QT, SRC_RP, SRC_RT, SRC_PG, SRC_TG
  } src_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ABS, OP_GT, OP_MOV, OP_OUT
  } op_e;

  typedef enum logic [1:0] {CND_ALWAYS, CND_PASS, CND_GATE} cond_e;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_WAIT} state_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    src_e  dst;
    src_e  a;
    src_e  b;
  } instr_t;

  typedef struct packed {
    logic            neg;
    logic            over;
    logic [MagW-1:0] mag;
  } unit_res_t;

  function automatic instr_t mk(input op_e op, input cond_e cond, input src_e dst,
                                input src_e a, input src_e b);
    instr_t i;
    i.op = op; i.cond = cond; i.dst = dst; i.a = a; i.b = b;
    return i;
  endfunction

  function automatic instr_t prog_rom(input logic [PcW-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(OP_ADD, CND_ALWAYS, SRC_PH,  SRC_PH,  SRC_PER);
      6'd1:  i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_P00, SRC_P10);
      6'd2:  i = mk(OP_ADD, CND_ALWAYS, SRC_T1,  SRC_P01, SRC_P11);
      6'd3:  i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T1);
      6'd4:  i = mk(OP_ADD, CND_ALWAYS, SRC_H00, SRC_T0,  SRC_QP);
      6'd5:  i = mk(OP_ADD, CND_ALWAYS, SRC_H01, SRC_P01, SRC_P11);
      6'd6:  i = mk(OP_ADD, CND_ALWAYS, SRC_H10, SRC_P10, SRC_P11);
      6'd7:  i = mk(OP_ADD, CND_ALWAYS, SRC_H11, SRC_P11, SRC_QT);
      6'd8:  i = mk(OP_ADD, CND_ALWAYS, SRC_S00, SRC_H00, SRC_RP);
      6'd9:  i = mk(OP_ADD, CND_ALWAYS, SRC_S11, SRC_H11, SRC_RT);
      6'd10: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_S00, SRC_S11);
      6'd11: i = mk(OP_MUL, CND_ALWAYS, SRC_T1,  SRC_H01, SRC_H10);
      6'd12: i = mk(OP_SUB, CND_ALWAYS, SRC_DET, SRC_T0,  SRC_T1);
      6'd13: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_H00, SRC_S11);
      6'd14: i = mk(OP_SUB, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T1);
      6'd15: i = mk(OP_DIV, CND_ALWAYS, SRC_K00, SRC_T0,  SRC_DET);
      6'd16: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_H01, SRC_S00);
      6'd17: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_H00, SRC_H01);
      6'd18: i = mk(OP_SUB, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd19: i = mk(OP_DIV, CND_ALWAYS, SRC_K01, SRC_T0,  SRC_DET);
      6'd20: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_H10, SRC_S11);
      6'd21: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_H11, SRC_H10);
      6'd22: i = mk(OP_SUB, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd23: i = mk(OP_DIV, CND_ALWAYS, SRC_K10, SRC_T0,  SRC_DET);
      6'd24: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_H11, SRC_S00);
      // The product of the two off-diagonal terms is still held in T1.
      6'd25: i = mk(OP_SUB, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T1);
      6'd26: i = mk(OP_DIV, CND_ALWAYS, SRC_K11, SRC_T0,  SRC_DET);
      6'd27: i = mk(OP_SUB, CND_ALWAYS, SRC_Y0,  SRC_M0,  SRC_PH);
      6'd28: i = mk(OP_SUB, CND_ALWAYS, SRC_Y1,  SRC_M1,  SRC_PER);
      6'd29: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_K00, SRC_Y0);
      6'd30: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_K01, SRC_Y1);
      6'd31: i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd32: i = mk(OP_ADD, CND_ALWAYS, SRC_PH,  SRC_PH,  SRC_T0);
      6'd33: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_K10, SRC_Y0);
      6'd34: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_K11, SRC_Y1);
      6'd35: i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd36: i = mk(OP_ADD, CND_ALWAYS, SRC_PER, SRC_PER, SRC_T0);
      6'd37: i = mk(OP_SUB, CND_ALWAYS, SRC_T0,  SRC_PH,  SRC_M0);
      6'd38: i = mk(OP_ABS, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T0);
      6'd39: i = mk(OP_GT,  CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_PG);
      6'd40: i = mk(OP_SUB, CND_ALWAYS, SRC_T0,  SRC_M1,  SRC_PER);
      6'd41: i = mk(OP_ABS, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T0);
      6'd42: i = mk(OP_GT,  CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_TG);
      6'd43: i = mk(OP_MOV, CND_GATE,   SRC_PH,  SRC_M0,  SRC_M0);
      6'd44: i = mk(OP_MOV, CND_GATE,   SRC_PER, SRC_M1,  SRC_M1);
      6'd45: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_K00, SRC_H00);
      6'd46: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_K01, SRC_H10);
      6'd47: i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd48: i = mk(OP_SUB, CND_PASS,   SRC_P00, SRC_H00, SRC_T0);
      6'd49: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_K00, SRC_H01);
      6'd50: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_K01, SRC_H11);
      6'd51: i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd52: i = mk(OP_SUB, CND_PASS,   SRC_P01, SRC_H01, SRC_T0);
      6'd53: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_K10, SRC_H00);
      6'd54: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_K11, SRC_H10);
      6'd55: i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd56: i = mk(OP_SUB, CND_PASS,   SRC_P10, SRC_H10, SRC_T0);
      6'd57: i = mk(OP_MUL, CND_ALWAYS, SRC_T0,  SRC_K10, SRC_H01);
      6'd58: i = mk(OP_MUL, CND_ALWAYS, SRC_T2,  SRC_K11, SRC_H11);
      6'd59: i = mk(OP_ADD, CND_ALWAYS, SRC_T0,  SRC_T0,  SRC_T2);
      6'd60: i = mk(OP_SUB, CND_PASS,   SRC_P11, SRC_H11, SRC_T0);
      default: i = mk(OP_OUT, CND_ALWAYS, SRC_T0, SRC_PH, SRC_PER);
    endcase
    return i;
  endfunction

  // Reset contents of the scratch memory, Q.16 milliseconds.
  function automatic logic [MagW-1:0] mem_reset(input src_e r);
    logic [MagW-1:0] v;
    case (r)
      SRC_PER: v = MagW'(500) << 16;
      SRC_P00: v = MagW'(15) << 16;
      SRC_P11: v = MagW'(9) << 16;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ktpt_mul.sv
module ktpt_mul import ktpt_pkg::*; #(
  parameter int W = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output unit_res_t           res_o
);

  localparam logic [2:0] LastStep = 3'd4;

  logic [MagW-1:0]   ma_q, mb_q;
  logic              neg_q;
  logic [2*MagW-1:0] acc_q, pp, rnd;
  logic [31:0]       xa, xb;
  logic [63:0]       prod;
  logic [2:0]        step_q;
  logic              busy_q, done_q;
  unit_res_t         res_q;
  logic [W-1:0]      am, bm;

  assign am = a_i[W-1] ? W'(-a_i) : a_i;
  assign bm = b_i[W-1] ? W'(-b_i) : b_i;

  // Four 32 by 32 partial products, one per cycle, then a rounding step.
  always_comb begin
    xa   = step_q[1] ? ma_q[63:32] : ma_q[31:0];
    xb   = step_q[0] ? mb_q[63:32] : mb_q[31:0];
    prod = 64'(xa) * 64'(xb);
    case (step_q)
      3'd0:    pp = (2*MagW)'(prod);
      3'd3:    pp = (2*MagW)'(prod) << 64;
      default: pp = (2*MagW)'(prod) << 32;
    endcase
    rnd = acc_q + ((2*MagW)'(1) << 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == LastStep) busy_q <= 1'b0;
        else step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= MagW'(am);
      mb_q  <= MagW'(bm);
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q == LastStep) begin
        res_q.neg  <= neg_q;
        res_q.over <= |rnd[127:80];
        res_q.mag  <= rnd[79:16];
      end else begin
        acc_q <= acc_q + pp;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/core/ktpt_div.sv
module ktpt_div import ktpt_pkg::*; #(
  parameter int W = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic                done_o,
  output unit_res_t           res_o
);

  localparam int DvW  = W + 16;
  localparam int CntW = $clog2(DvW + 1);

  logic [W-1:0]      d_q, rem_q, rem_d, nm, dm;
  logic [DvW-1:0]    dvd_q, quot_q;
  logic [W:0]        trial, diff;
  logic              ge, neg_q, zero_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [2*MagW-1:0] qext;
  unit_res_t         res_q;

  assign nm = num_i[W-1] ? W'(-num_i) : num_i;
  assign dm = den_i[W-1] ? W'(-den_i) : den_i;

  // Restoring division, one quotient bit per cycle. The remainder stays
  // below the divisor, so the new remainder never needs the trial's top bit.
  always_comb begin
    trial = {rem_q, dvd_q[DvW-1]};
    diff  = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
    rem_d = ge ? diff[W-1:0] : trial[W-1:0];
    qext  = (2*MagW)'(quot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvW);
      end else if (busy_q) begin
        if (cnt_q == '0) busy_q <= 1'b0;
        else cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q    <= dm;
      rem_q  <= '0;
      dvd_q  <= {nm, 16'd0};
      quot_q <= '0;
      neg_q  <= num_i[W-1] ^ den_i[W-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        res_q.neg  <= neg_q;
        res_q.over <= !zero_q && (|qext[127:64]);
        res_q.mag  <= zero_q ? '0 : qext[63:0];
      end else begin
        rem_q  <= rem_d;
        dvd_q  <= {dvd_q[DvW-2:0], 1'b0};
        quot_q <= {quot_q[DvW-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/core/kalman_tempo_phase_tracker_top.sv
// Two-state Kalman tracker for beat phase and beat period. Each request is
// run by a small sequencer through one micro-program over a 22-entry scratch
// memory, using a shared saturating adder, a multiplier that forms one
// 32x32 partial product per cycle and a bit-serial divider. A measurement
// runs 37 add-type steps, 20 multiplies and 4 divides; a restart request
// runs only the tail of the program. No new request is taken until the
// result is in the output register; that register can hold one result
// while the next request is accepted.
`include "kalman_tempo_phase_tracker_top_defines.svh"

module kalman_tempo_phase_tracker_top import ktpt_pkg::*; #(
  parameter int DATA_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [35:0] phase_meas, [59:36] tempo_meas, [63:60] zero
  input  logic [63:0] s_axis_tdata_i,
  // [0] command
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [36:0] phase_est, [61:37] tempo_est, [63:62] zero
  output logic [63:0] m_axis_tdata_o,
  // [0] restarted
  output logic        m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int W     = DATA_WIDTH;
  localparam int MemAw = $clog2(NumMem);
  localparam logic [MagW-1:0] MagMax = (MagW'(1) << (W-1)) - MagW'(1);
  localparam logic signed [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMin : WMax;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMin : WMax;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_abs(input logic signed [W-1:0] a);
    if (!a[W-1]) return a;
    return (a == WMin) ? WMax : W'(-a);
  endfunction

  function automatic logic signed [W-1:0] from_mag(input unit_res_t r);
    if (r.neg) begin
      if (r.over || r.mag > MagMax + MagW'(1)) return WMin;
      return W'(-r.mag);
    end
    if (r.over || r.mag > MagMax) return WMax;
    return W'(r.mag);
  endfunction

  function automatic logic signed [W-1:0] widen(input logic [MagW-1:0] v);
    logic [MagW-1:0] s;
    s = v << 8;
    return (s > MagMax) ? WMax : W'(s);
  endfunction

  // Floor of value / 256, clamped to a signed field of the given width.
  function automatic logic [63:0] to_field(input logic signed [W-1:0] v, input int bits);
    logic signed [W-1:0] sh;
    logic signed [63:0]  e, hi, lo;
    sh = v >>> 8;
    e  = 64'(sh);
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (e > hi) e = hi;
    if (e < lo) e = lo;
    return e;
  endfunction

  state_e              state_q, state_d;
  logic [PcW-1:0]      pc_q, pc_d;
  instr_t              inst;
  logic                gate_q, gate_d;
  logic signed [W-1:0] m0_q, m1_q;
  logic [23:0]         qp_q, qt_q, rp_q, rt_q, pg_q, tg_q;
  logic signed [W-1:0] mem [NumMem];
  logic [NumMem-1:0]   valid_q;
  logic signed [W-1:0] rd_a_q, rd_b_q;
  logic                va_q, vb_q;
  logic [MemAw-1:0]    ia, ib, wa;
  logic signed [W-1:0] spec_a, spec_b, opa, opb, wr_data;
  logic                wr_en, cond_ok, out_free, out_load;
  logic                mul_start, div_start, mul_done, div_done, unit_done;
  unit_res_t           mul_res, div_res;
  logic                m_valid_q, m_user_q;
  logic [63:0]         m_data_q, fa, fb;

  assign inst = prog_rom(pc_q);
  assign ia   = (inst.a < SRC_M0) ? MemAw'(inst.a) : '0;
  assign ib   = (inst.b < SRC_M0) ? MemAw'(inst.b) : '0;
  assign wa   = MemAw'(inst.dst);

  always_comb begin
    case (inst.a)
      SRC_M0:  spec_a = m0_q;
      SRC_M1:  spec_a = m1_q;
      SRC_QP:  spec_a = widen(MagW'(qp_q));
      SRC_QT:  spec_a = widen(MagW'(qt_q));
      SRC_RP:  spec_a = widen(MagW'(rp_q));
      SRC_RT:  spec_a = widen(MagW'(rt_q));
      SRC_PG:  spec_a = widen(MagW'(pg_q));
      SRC_TG:  spec_a = widen(MagW'(tg_q));
      default: spec_a = '0;
    endcase
    case (inst.b)
      SRC_M0:  spec_b = m0_q;
      SRC_M1:  spec_b = m1_q;
      SRC_QP:  spec_b = widen(MagW'(qp_q));
      SRC_QT:  spec_b = widen(MagW'(qt_q));
      SRC_RP:  spec_b = widen(MagW'(rp_q));
      SRC_RT:  spec_b = widen(MagW'(rt_q));
      SRC_PG:  spec_b = widen(MagW'(pg_q));
      SRC_TG:  spec_b = widen(MagW'(tg_q));
      default: spec_b = '0;
    endcase
    opa = (inst.a < SRC_M0) ? (va_q ? rd_a_q : W'(mem_reset(inst.a))) : spec_a;
    opb = (inst.b < SRC_M0) ? (vb_q ? rd_b_q : W'(mem_reset(inst.b))) : spec_b;
  end

  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign unit_done = mul_done || div_done;

  // Next state.
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_READ;
          pc_d    = s_axis_tuser_i ? PcRestart : '0;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        case (inst.op)
          OP_MUL, OP_DIV: state_d = ST_WAIT;
          OP_OUT: begin
            if (out_free) state_d = ST_IDLE;
          end
          default: begin
            state_d = ST_READ;
            pc_d    = pc_q + PcW'(1);
          end
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          state_d = ST_READ;
          pc_d    = pc_q + PcW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and the shared adder.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    mul_start       = 1'b0;
    div_start       = 1'b0;
    wr_en           = 1'b0;
    wr_data         = opa;
    gate_d          = gate_q;
    out_load        = 1'b0;
    case (inst.cond)
      CND_PASS: cond_ok = !gate_q;
      CND_GATE: cond_ok = gate_q;
      default:  cond_ok = 1'b1;
    endcase
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) gate_d = s_axis_tuser_i;
      end
      ST_EXEC: begin
        case (inst.op)
          OP_ADD: begin
            wr_en   = cond_ok;
            wr_data = sat_add(opa, opb);
          end
          OP_SUB: begin
            wr_en   = cond_ok;
            wr_data = sat_sub(opa, opb);
          end
          OP_ABS: begin
            wr_en   = cond_ok;
            wr_data = sat_abs(opa);
          end
          OP_MOV:  wr_en = cond_ok;
          OP_GT:   gate_d = gate_q || (opa > opb);
          OP_MUL:  mul_start = 1'b1;
          OP_DIV:  div_start = 1'b1;
          OP_OUT:  out_load = out_free;
          default: wr_en = 1'b0;
        endcase
      end
      ST_WAIT: begin
        wr_en   = unit_done && cond_ok;
        wr_data = from_mag(mul_done ? mul_res : div_res);
      end
      default: wr_en = 1'b0;
    endcase
  end

  ktpt_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  ktpt_div #(.W(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa),
    .den_i   (opb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wa] <= wr_data;
    rd_a_q <= mem[ia];
    rd_b_q <= mem[ib];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      gate_q    <= 1'b0;
      valid_q   <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      gate_q  <= gate_d;
      va_q    <= valid_q[ia];
      vb_q    <= valid_q[ib];
      if (wr_en) valid_q[wa] <= 1'b1;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qp_q <= 24'd6400;
      qt_q <= 24'd205;
      rp_q <= 24'd25600;
      rt_q <= 24'd4096;
      pg_q <= 24'd25600;
      tg_q <= 24'd3840;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_Q_PHASE:    qp_q <= cfg_data_i;
        CFG_Q_TEMPO:    qt_q <= cfg_data_i;
        CFG_R_PHASE:    rp_q <= cfg_data_i;
        CFG_R_TEMPO:    rt_q <= cfg_data_i;
        CFG_PHASE_GATE: pg_q <= cfg_data_i;
        CFG_TEMPO_GATE: tg_q <= cfg_data_i;
        default:        qp_q <= qp_q;
      endcase
    end
  end

  assign fa = to_field(opa, 37);
  assign fb = to_field(opb, 25);

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      m0_q <= widen(MagW'(s_axis_tdata_i[35:0]));
      m1_q <= widen(MagW'(s_axis_tdata_i[59:36]));
    end
    if (out_load) begin
      m_data_q <= {2'b00, fb[24:0], fa[36:0]};
      m_user_q <= gate_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  `KTPT_ASSERT(a_accept_starts, (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == ST_READ), "accepted request did not start the program")
  `KTPT_ASSERT(a_out_from_prog, $rose(m_valid_q) |-> $past(state_q == ST_EXEC && inst.op == OP_OUT), "result appeared outside the output step")
  `KTPT_ASSERT_ALWAYS(a_done_in_wait, (mul_done || div_done) |-> (state_q == ST_WAIT), "arithmetic unit finished while sequencer was not waiting")

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ktpt_pkg::*;

  localparam longint WMAX = (64'sd1 <<< 47) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam bit CMD_MEASURE = 1'b0;
  localparam bit CMD_RESTART = 1'b1;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [36:0] phase;
    logic [24:0] tempo;
    logic        restarted;
  } estimate_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  kalman_tempo_phase_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Tracker copy: estimate, error covariance and registers.
  longint      trk_phase, trk_period;
  longint      trk_cov [4];
  logic [23:0] trk_regs [6];

  estimate_t   estimate_q [$];
  int          error_count = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          gate_restarts = 0;
  int          config_writes = 0;
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;
  int          sink_wait = 0;
  longint      cycle_count = 0;

  function automatic longint clamp(input longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint from_mag(input bit neg, input logic [127:0] m);
    if (neg) return (m > 128'(WMAX) + 1) ? WMIN : -longint'(m[63:0]);
    return (m > 128'(WMAX)) ? WMAX : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] prod;
    prod = 128'(magnitude(a)) * 128'(magnitude(b)) + 128'd32768;
    return from_mag((a < 0) != (b < 0), prod >> 16);
  endfunction

  function automatic longint fx_div(input longint num, input longint den);
    logic [127:0] q;
    if (den == 0) return 0;
    q = (128'(magnitude(num)) << 16) / 128'(magnitude(den));
    return from_mag((num < 0) != (den < 0), q);
  endfunction

  function automatic longint widen(input logic [35:0] v);
    return longint'({20'b0, v, 8'b0});
  endfunction

  function automatic longint abs_sat(input longint v);
    if (v >= 0) return v;
    return v == WMIN ? WMAX : -v;
  endfunction

  function automatic longint to_field(input longint v, input int bits);
    longint q, hi;
    q = v >>> 8;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return q;
  endfunction

  task automatic track_step(input bit cmd, input logic [35:0] pm, input logic [23:0] tm,
                            output estimate_t est);
    longint m0, m1, h00, h01, h10, h11, s00, s11, det, k00, k01, k10, k11, y0, y1;
    bit fired;
    m0 = widen(pm);
    m1 = widen({12'b0, tm});
    fired = 1'b1;
    if (cmd == CMD_MEASURE) begin
      trk_phase = clamp(trk_phase + trk_period);
      h01 = clamp(trk_cov[1] + trk_cov[3]);
      h10 = clamp(trk_cov[2] + trk_cov[3]);
      h00 = clamp(clamp(clamp(trk_cov[0] + trk_cov[2]) + h01)
                  + widen(36'(trk_regs[CFG_Q_PHASE])));
      h11 = clamp(trk_cov[3] + widen(36'(trk_regs[CFG_Q_TEMPO])));
      s00 = clamp(h00 + widen(36'(trk_regs[CFG_R_PHASE])));
      s11 = clamp(h11 + widen(36'(trk_regs[CFG_R_TEMPO])));
      det = clamp(fx_mul(s00, s11) - fx_mul(h01, h10));
      k00 = fx_div(clamp(fx_mul(h00, s11) - fx_mul(h01, h10)), det);
      k01 = fx_div(clamp(fx_mul(h01, s00) - fx_mul(h00, h01)), det);
      k10 = fx_div(clamp(fx_mul(h10, s11) - fx_mul(h11, h10)), det);
      k11 = fx_div(clamp(fx_mul(h11, s00) - fx_mul(h10, h01)), det);
      y0 = clamp(m0 - trk_phase);
      y1 = clamp(m1 - trk_period);
      trk_phase = clamp(trk_phase + clamp(fx_mul(k00, y0) + fx_mul(k01, y1)));
      trk_period = clamp(trk_period + clamp(fx_mul(k10, y0) + fx_mul(k11, y1)));
      if (abs_sat(clamp(trk_phase - m0)) > widen(36'(trk_regs[CFG_PHASE_GATE])) ||
          abs_sat(clamp(m1 - trk_period)) > widen(36'(trk_regs[CFG_TEMPO_GATE]))) begin
        gate_restarts++;
      end else begin
        fired = 1'b0;
        trk_cov[0] = clamp(h00 - clamp(fx_mul(k00, h00) + fx_mul(k01, h10)));
        trk_cov[1] = clamp(h01 - clamp(fx_mul(k00, h01) + fx_mul(k01, h11)));
        trk_cov[2] = clamp(h10 - clamp(fx_mul(k10, h00) + fx_mul(k11, h10)));
        trk_cov[3] = clamp(h11 - clamp(fx_mul(k10, h01) + fx_mul(k11, h11)));
      end
    end
    if (fired) begin
      trk_phase = m0;
      trk_period = m1;
    end
    est.phase = 37'(to_field(trk_phase, 37));
    est.tempo = 25'(to_field(trk_period, 25));
    est.restarted = fired;
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random back-pressure plus an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_tready = 1'b0;
      hold_cycles--;
    end else if (sink_wait > 0) begin
      m_tready = 1'b0;
      sink_wait--;
    end else begin
      m_tready = 1'b1;
      if ($urandom_range(0, 3) == 0) sink_wait = pick_gap();
    end
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    estimate_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_ni && m_tvalid && m_tready) begin
      results_seen++;
      if (estimate_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = estimate_q.pop_front();
        if (m_tdata[36:0] !== want.phase)
          report_mismatch("phase_est", $signed(m_tdata[36:0]), $signed(want.phase));
        if (m_tdata[61:37] !== want.tempo)
          report_mismatch("tempo_est", $signed(m_tdata[61:37]), $signed(want.tempo));
        if (m_tuser !== want.restarted)
          report_mismatch("restarted", m_tuser, want.restarted);
      end
    end
  end

  task automatic send_request(input bit cmd, input logic [35:0] pm, input logic [23:0] tm);
    estimate_t est;
    repeat (pick_gap()) @(negedge clk_i);
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {4'b0, tm, pm};
    do @(posedge clk_i); while (!s_tready);
    track_step(cmd, pm, tm, est);
    estimate_q.push_back(est);
    requests_sent++;
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    wait (estimate_q.size() == 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] value);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    trk_regs[idx] = value;
    config_writes++;
  endtask

  task automatic load_config(input logic [23:0] qp, qt, rp, rt, pg, tg);
    wait_idle();
    write_reg(CFG_Q_PHASE, qp);
    write_reg(CFG_Q_TEMPO, qt);
    write_reg(CFG_R_PHASE, rp);
    write_reg(CFG_R_TEMPO, rt);
    write_reg(CFG_PHASE_GATE, pg);
    write_reg(CFG_TEMPO_GATE, tg);
  endtask

  function automatic logic [23:0] pick_reg(input int typical);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd0;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom_range(1, typical));
  endfunction

  // A restart followed by plausible beats with jitter and the odd outlier.
  task automatic run_beats(input int count);
    longint truth, pm;
    int tempo, tm;
    truth = longint'($urandom) << $urandom_range(0, 3);
    tempo = $urandom_range(40000, 250000);
    send_request(CMD_RESTART, 36'(truth), 24'(tempo));
    repeat (count) begin
      truth += tempo;
      pm = truth + $urandom_range(0, 16000) - 8000;
      tm = tempo + $urandom_range(0, 3000) - 1500;
      if ($urandom_range(0, 15) == 0) pm += $urandom_range(0, 200000);
      if ($urandom_range(0, 15) == 0) tm += $urandom_range(0, 20000);
      if (pm < 0) pm = 0;
      send_request(CMD_MEASURE, 36'(pm), 24'(tm));
    end
  endtask

  task automatic send_noise();
    send_request(bit'($urandom_range(0, 1)), 36'({$urandom, $urandom}), 24'($urandom));
  endtask

  task automatic test_directed();
    logic [35:0] pmax;
    pmax = '1;
    send_request(CMD_MEASURE, 36'd0, 24'd0);
    send_request(CMD_MEASURE, pmax, 24'hFFFFFF);
    send_request(CMD_RESTART, pmax, 24'hFFFFFF);
    send_request(CMD_MEASURE, pmax, 24'hFFFFFF);
    send_request(CMD_RESTART, 36'd0, 24'd0);
    send_request(CMD_MEASURE, 36'd0, 24'd0);
    send_request(CMD_RESTART, 36'd1000000, 24'd128000);
    send_request(CMD_MEASURE, 36'd1128000, 24'd128000);
    send_request(CMD_MEASURE, 36'd1256500, 24'd128200);
    send_request(CMD_MEASURE, 36'd1900000, 24'd128000);
    send_request(CMD_MEASURE, 36'd2028000, 24'd150000);
    // With both gates at zero, a beat exactly on the prediction must pass
    // and one unit off must fire.
    load_config(24'd6400, 24'd205, 24'd25600, 24'd4096, 24'd0, 24'd0);
    send_request(CMD_RESTART, 36'd5000000, 24'd128000);
    send_request(CMD_MEASURE, 36'd5128000, 24'd128000);
    send_request(CMD_MEASURE, 36'd5256001, 24'd128000);
    send_request(CMD_MEASURE, 36'd5384000, 24'd128001);
  endtask

  task automatic test_config_sweep();
    // Zero noise terms: the gain becomes the identity, the covariance collapses
    // and the determinant then goes to zero.
    load_config(24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
    run_beats(30);
    load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    run_beats(30);
    load_config(24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1, 24'd25600, 24'd3840);
    run_beats(30);
    load_config(24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0);
    run_beats(30);
    load_config(24'd6400, 24'd205, 24'd25600, 24'd4096, 24'd25600, 24'd3840);
    run_beats(30);
  endtask

  task automatic test_backpressure();
    wait_idle();
    idle_on = 1'b0;
    hold_cycles = 3000;
    run_beats(8);
    wait_idle();
    idle_on = 1'b1;
    run_beats(8);
  endtask

  task automatic test_random();
    int sent, n;
    repeat (16) begin
      wait_idle();
      if ($urandom_range(0, 1))
        load_config(pick_reg(20000), pick_reg(2000), pick_reg(60000), pick_reg(10000),
                    pick_reg(60000), pick_reg(10000));
      idle_on = $urandom_range(0, 3) != 0;
      sent = 0;
      while (sent < 95) begin
        if ($urandom_range(0, 99) < 85) begin
          n = $urandom_range(4, 25);
          run_beats(n);
          sent += n + 1;
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) send_noise();
          sent += n;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    trk_phase = 0;
    trk_period = longint'(500) << 16;
    trk_cov[0] = longint'(15) << 16;
    trk_cov[1] = 0;
    trk_cov[2] = 0;
    trk_cov[3] = longint'(9) << 16;
    trk_regs[CFG_Q_PHASE] = 24'd6400;
    trk_regs[CFG_Q_TEMPO] = 24'd205;
    trk_regs[CFG_R_PHASE] = 24'd25600;
    trk_regs[CFG_R_TEMPO] = 24'd4096;
    trk_regs[CFG_PHASE_GATE] = 24'd25600;
    trk_regs[CFG_TEMPO_GATE] = 24'd3840;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait (estimate_q.size() == 0);
    repeat (1000) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d gate restarts, %0d register writes.",
             requests_sent, results_seen, gate_restarts, config_writes);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
